/* rtl/spectral_current_field_top_assert.svh */
// Assertion macros for the spectral current field block.
`ifndef SPECTRAL_CURRENT_FIELD_TOP_ASSERT_SVH
`define SPECTRAL_CURRENT_FIELD_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SCF_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("scf check failed");
`define SCF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("scf check failed");
`else
`define SCF_ASSERT_IMPL(label, clk, rst, pre, post)
`define SCF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* rtl/scf_pkg.sv */
// Package: constants, types and tables of the spectral current field block.
`default_nettype none
package scf_pkg;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int FRAC_BITS_DEF     = 16;
   localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
   localparam logic [29:0] PHASE_SCALE = 30'd777472128;
   localparam logic [15:0] AMP_SCALE   = 16'd33733;
   localparam int AMP_FRAC = 14;
   localparam logic [63:0] FIELD_CLAMP = 64'd1 << 36;

   typedef enum logic [2:0] {
      REG_ROTATION  = 3'd0,
      REG_OFFSET_X  = 3'd1,
      REG_OFFSET_Y  = 3'd2,
      REG_WAVE      = 3'd3,
      REG_AMPLITUDE = 3'd4,
      REG_CORIOLIS  = 3'd5,
      REG_GRAVITY   = 3'd6
   } scf_reg_type;

   typedef enum logic [2:0] {
      CFG_IDLE, CFG_MUL1, CFG_MUL2, CFG_MUL3, CFG_DIV
   } scf_state_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] wave;
      logic [15:0] off_x;
      logic [15:0] off_y;
      logic [63:0] amp;
   } scf_cfg_type;

   function automatic logic [31:0] scf_atan(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/spectral_current_field_top.sv */
// Top level of the spectral current field: position in, drift velocity out.
//
//  channel   ports                          handshake
//  request   req_pos_x, req_pos_y           req_valid / req_stall
//  result    rsp_drift_east, rsp_drift_north rsp_valid / rsp_stall
//  config    psel penable pwrite paddr ...  APB, pready tied high
//
// One request per cycle while req_stall is low; a request passes the rotation and
// phase stages, the phase CORDIC pipeline and the field stages. After reset and after any
// register write the amplitude engine runs its multiplies and divide, holding req_stall.
// A stalled result sits in the output register while the pipeline keeps filling;
// the whole pipeline freezes only when its last stage and the output are full.
`default_nettype none
module spectral_current_field_top import scf_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire signed [31:0]  req_pos_x,
   input  wire signed [31:0]  req_pos_y,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_drift_east,
   output logic signed [31:0] rsp_drift_north,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [4:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   `include "spectral_current_field_top_assert.svh"

   localparam int CW   = FRAC_BITS + 2;
   localparam int MW   = CW - 1;
   localparam int FX_W = 33 + CW - FRAC_BITS;
   localparam int DW   = 38;
   localparam int EW   = DW + CW + 1;

   scf_cfg_type           cfg;
   logic signed [CW-1:0]  rc, rs;

   scf_csr #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg),
      .rot_cos(rc), .rot_sin(rs)
   );
   assign pready = 1'b1;

   logic en, accept;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, rsp_valid_ff;

   assign en        = !f5_ff || !rsp_valid_ff || !rsp_stall;
   assign req_stall = cfg.busy || !en;
   assign accept    = req_valid && !req_stall;

   // position rotation into the field frame
   logic signed [31:0]        x1_ff, y1_ff;
   logic signed [32+CW-1:0]   cx_ff, sy_ff, cy_ff, sx_ff;
   logic signed [33+CW-1:0]   sum_x, sum_y, shx, shy;
   logic signed [FX_W-1:0]    fx_ff, fy_ff;
   // phase
   logic signed [55:0]        mx_in, my_in, mx_ff, my_ff;
   logic [57:0]               plx, phx, ply, phy;
   logic [55:0]               plx_ff, ply_ff, px, py;
   logic [27:0]               phx_ff, phy_ff;
   logic [31:0]               phase_x_ff, phase_y_ff;

   assign sum_x = (33+CW)'(cx_ff) + (33+CW)'(sy_ff);
   assign sum_y = (33+CW)'(cy_ff) - (33+CW)'(sx_ff);
   assign shx   = sum_x >>> FRAC_BITS;
   assign shy   = sum_y >>> FRAC_BITS;
   assign mx_in = 56'($signed({1'b0, cfg.wave})) * 56'(fx_ff);
   assign my_in = 56'($signed({1'b0, cfg.wave})) * 56'(fy_ff);
   assign plx   = 58'(mx_ff[27:0]) * 58'(PHASE_SCALE);
   assign phx   = 58'(mx_ff[55:28]) * 58'(PHASE_SCALE);
   assign ply   = 58'(my_ff[27:0]) * 58'(PHASE_SCALE);
   assign phy   = 58'(my_ff[55:28]) * 58'(PHASE_SCALE);
   assign px    = plx_ff + {phx_ff, 28'h0};
   assign py    = ply_ff + {phy_ff, 28'h0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff;  v5_ff <= v4_ff; v6_ff <= v5_ff;
      end
      if (en) begin
         x1_ff      <= req_pos_x;
         y1_ff      <= req_pos_y;
         cx_ff      <= (32+CW)'(rc) * (32+CW)'(x1_ff);
         sy_ff      <= (32+CW)'(rs) * (32+CW)'(y1_ff);
         cy_ff      <= (32+CW)'(rc) * (32+CW)'(y1_ff);
         sx_ff      <= (32+CW)'(rs) * (32+CW)'(x1_ff);
         fx_ff      <= shx[FX_W-1:0];
         fy_ff      <= shy[FX_W-1:0];
         mx_ff      <= mx_in;
         my_ff      <= my_in;
         plx_ff     <= plx[55:0];
         phx_ff     <= phx[27:0];
         ply_ff     <= ply[55:0];
         phy_ff     <= phy[27:0];
         phase_x_ff <= px[55:24] + {cfg.off_x, 16'h0};
         phase_y_ff <= py[55:24] + {cfg.off_y, 16'h0};
      end
   end

   logic                 cv;
   logic signed [CW-1:0] cqx, cqy;
   scf_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_phx (
      .clock(clock), .reset(reset), .en(en), .in_valid(v6_ff), .in_turn(phase_x_ff),
      .out_valid(cv), .out_cos(cqx), .out_sin()
   );
   scf_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_phy (
      .clock(clock), .reset(reset), .en(en), .in_valid(v6_ff), .in_turn(phase_y_ff),
      .out_valid(), .out_cos(cqy), .out_sin()
   );

   // field components, then rotation back
   logic signed [CW-1:0]    ax, ay;
   logic [MW-1:0]           mgx, mgy;
   logic [32+MW-1:0]        lox_ff, hix_ff, loy_ff, hiy_ff;
   logic                    nx1_ff, ny1_ff, nx2_ff, ny2_ff;
   logic [64+MW-1:0]        fullx_ff, fully_ff;
   logic [63:0]             shvx, shvy, magx, magy;
   logic signed [DW-1:0]    dx_ff, dy_ff;
   logic signed [DW+CW-1:0] cdx_ff, sdy_ff, sdx_ff, cdy_ff;
   logic signed [EW-1:0]    e_sum, n_sum, e_sh, n_sh;
   logic signed [31:0]      east_ff, north_ff, east_sat, north_sat;
   logic signed [31:0]      rsp_east_ff, rsp_north_ff;

   assign ax   = cqx[CW-1] ? -cqx : cqx;
   assign ay   = cqy[CW-1] ? -cqy : cqy;
   assign mgx  = ax[MW-1:0];
   assign mgy  = ay[MW-1:0];
   assign shvx = fullx_ff[63:0] >> (AMP_FRAC + FRAC_BITS);
   assign shvy = fully_ff[63:0] >> (AMP_FRAC + FRAC_BITS);
   // a product past 64 bits or past 2^36 clamps
   assign magx = ((|fullx_ff[64+MW-1:64]) || shvx > FIELD_CLAMP) ? FIELD_CLAMP : shvx;
   assign magy = ((|fully_ff[64+MW-1:64]) || shvy > FIELD_CLAMP) ? FIELD_CLAMP : shvy;
   assign e_sum = EW'(cdx_ff) - EW'(sdy_ff);
   assign n_sum = EW'(sdx_ff) + EW'(cdy_ff);
   assign e_sh  = e_sum >>> FRAC_BITS;
   assign n_sh  = n_sum >>> FRAC_BITS;

   always_comb begin
      if (!e_sh[EW-1] && (|e_sh[EW-2:31]))      east_sat = 32'sh7FFFFFFF;
      else if (e_sh[EW-1] && !(&e_sh[EW-2:31])) east_sat = 32'sh80000000;
      else                                      east_sat = e_sh[31:0];
      if (!n_sh[EW-1] && (|n_sh[EW-2:31]))      north_sat = 32'sh7FFFFFFF;
      else if (n_sh[EW-1] && !(&n_sh[EW-2:31])) north_sat = 32'sh80000000;
      else                                      north_sat = n_sh[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= 1'b0; f2_ff <= 1'b0; f3_ff <= 1'b0; f4_ff <= 1'b0; f5_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            f1_ff <= cv; f2_ff <= f1_ff; f3_ff <= f2_ff; f4_ff <= f3_ff; f5_ff <= f4_ff;
         end
         rsp_valid_ff <= (en && f5_ff) || (rsp_valid_ff && rsp_stall);
      end
      if (en) begin
         lox_ff   <= (32+MW)'(cfg.amp[31:0]) * (32+MW)'(mgx);
         hix_ff   <= (32+MW)'(cfg.amp[63:32]) * (32+MW)'(mgx);
         loy_ff   <= (32+MW)'(cfg.amp[31:0]) * (32+MW)'(mgy);
         hiy_ff   <= (32+MW)'(cfg.amp[63:32]) * (32+MW)'(mgy);
         nx1_ff   <= cqx[CW-1];
         ny1_ff   <= cqy[CW-1];
         fullx_ff <= {hix_ff, 32'h0} + {32'h0, lox_ff};
         fully_ff <= {hiy_ff, 32'h0} + {32'h0, loy_ff};
         nx2_ff   <= nx1_ff;
         ny2_ff   <= ny1_ff;
         dx_ff    <= ny2_ff ? $signed({1'b0, magy[36:0]}) : -$signed({1'b0, magy[36:0]});
         dy_ff    <= nx2_ff ? -$signed({1'b0, magx[36:0]}) : $signed({1'b0, magx[36:0]});
         cdx_ff   <= (DW+CW)'(rc) * (DW+CW)'(dx_ff);
         sdy_ff   <= (DW+CW)'(rs) * (DW+CW)'(dy_ff);
         sdx_ff   <= (DW+CW)'(rs) * (DW+CW)'(dx_ff);
         cdy_ff   <= (DW+CW)'(rc) * (DW+CW)'(dy_ff);
         east_ff  <= east_sat;
         north_ff <= north_sat;
      end
      if (en && f5_ff) begin
         rsp_east_ff  <= east_ff;
         rsp_north_ff <= north_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drift_east  = rsp_east_ff;
   assign rsp_drift_north = rsp_north_ff;

   `SCF_ASSERT_IMPL(a_busy_stalls, clock, reset, cfg.busy, req_stall)
   `SCF_ASSERT_NEXT(a_accept_enters, clock, reset, accept, v1_ff)
   `SCF_ASSERT_NEXT(a_tail_holds, clock, reset, f5_ff && rsp_valid_ff && rsp_stall, f5_ff)
endmodule
`default_nettype wire

/* rtl/scf_cordic.sv */
// Pipelined rotation-mode CORDIC: cosine and sine of a 2^-32 turn angle.
`default_nettype none
module scf_cordic import scf_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          en,
   input  wire                          in_valid,
   input  wire  [31:0]                  in_turn,
   output logic                         out_valid,
   output logic signed [FRAC_BITS+1:0]  out_cos,
   output logic signed [FRAC_BITS+1:0]  out_sin
);
   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [33:0] HALF = 34'sd1 <<< (SH - 1);

   logic signed [33:0] x_ff [0:CORDIC_STAGES];
   logic signed [33:0] y_ff [0:CORDIC_STAGES];
   logic signed [33:0] z_ff [0:CORDIC_STAGES];
   logic               flip_ff [0:CORDIC_STAGES];
   logic               valid_ff [0:CORDIC_STAGES];
   logic               out_valid_ff;
   logic signed [FRAC_BITS+1:0] cos_ff, sin_ff;

   logic        flip_in;
   logic [31:0] turn_in;
   assign flip_in = in_turn[31] ^ in_turn[30];
   assign turn_in = flip_in ? (in_turn + 32'h80000000) : in_turn;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= $signed(CORDIC_GAIN);
         y_ff[0]    <= '0;
         z_ff[0]    <= {{2{turn_in[31]}}, turn_in};
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      localparam logic [4:0] K5 = 5'(k);
      logic signed [33:0] dx, dy, at;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign at = $signed({2'b00, scf_atan(K5)});
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            if (!z_ff[k][33]) begin
               x_ff[k+1] <= x_ff[k] - dx;
               y_ff[k+1] <= y_ff[k] + dy;
               z_ff[k+1] <= z_ff[k] - at;
            end else begin
               x_ff[k+1] <= x_ff[k] + dx;
               y_ff[k+1] <= y_ff[k] - dy;
               z_ff[k+1] <= z_ff[k] + at;
            end
            flip_ff[k+1] <= flip_ff[k];
         end
      end
   end

   logic signed [33:0] xf, yf, xr, yr;
   assign xf = flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign yf = flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];
   assign xr = (xf + HALF) >>> SH;
   assign yr = (yf + HALF) >>> SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[CORDIC_STAGES];
      end
      if (en) begin
         cos_ff <= xr[FRAC_BITS+1:0];
         sin_ff <= yr[FRAC_BITS+1:0];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
endmodule
`default_nettype wire

/* rtl/scf_csr.sv */
// Register file and derived field constants (amplitude, rotation cos/sin).
`default_nettype none
module scf_csr import scf_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [4:0]                   paddr,
   input  wire  [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output scf_cfg_type                  cfg,
   output logic signed [FRAC_BITS+1:0]  rot_cos,
   output logic signed [FRAC_BITS+1:0]  rot_sin
);
   logic [15:0] rotation_ff, off_x_ff, off_y_ff, wave_ff, ampl_ff, cor_ff, grav_ff;
   logic        wr;
   scf_reg_type idx;
   assign wr  = psel & penable & pwrite;
   assign idx = scf_reg_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= '0;
         off_x_ff    <= '0;
         off_y_ff    <= '0;
         wave_ff     <= '0;
         ampl_ff     <= '0;
         cor_ff      <= 16'd2114;
         grav_ff     <= 16'd2511;
      end else if (wr) begin
         case (idx)
            REG_ROTATION:  rotation_ff <= pwdata[15:0];
            REG_OFFSET_X:  off_x_ff    <= pwdata[15:0];
            REG_OFFSET_Y:  off_y_ff    <= pwdata[15:0];
            REG_WAVE:      wave_ff     <= pwdata[15:0];
            REG_AMPLITUDE: ampl_ff     <= pwdata[15:0];
            REG_CORIOLIS:  cor_ff      <= pwdata[15:0];
            REG_GRAVITY:   grav_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROTATION:  prdata = {16'h0, rotation_ff};
         REG_OFFSET_X:  prdata = {16'h0, off_x_ff};
         REG_OFFSET_Y:  prdata = {16'h0, off_y_ff};
         REG_WAVE:      prdata = {16'h0, wave_ff};
         REG_AMPLITUDE: prdata = {16'h0, ampl_ff};
         REG_CORIOLIS:  prdata = {16'h0, cor_ff};
         REG_GRAVITY:   prdata = {16'h0, grav_ff};
         default:       prdata = '0;
      endcase
   end

   // amplitude engine: three multiplies, then a bit-serial divide
   scf_state_type state_ff, state_in;
   logic [31:0] p1_ff;
   logic [47:0] p2_ff;
   logic [63:0] num_ff, amp_ff;
   logic [15:0] rem_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy, rot_start;

   always_comb begin
      state_in = state_ff;
      if (wr) begin
         state_in = CFG_MUL1;
      end else begin
         case (state_ff)
            CFG_IDLE: state_in = CFG_IDLE;
            CFG_MUL1: state_in = CFG_MUL2;
            CFG_MUL2: state_in = CFG_MUL3;
            CFG_MUL3: state_in = CFG_DIV;
            CFG_DIV:  state_in = (cnt_ff == 6'd0) ? CFG_IDLE : CFG_DIV;
            default:  state_in = CFG_IDLE;
         endcase
      end
   end

   always_comb begin
      busy      = (state_ff != CFG_IDLE);
      rot_start = (state_ff == CFG_MUL1);
   end

   logic [16:0] rem_sh, rem_nx;
   logic        ge;
   assign rem_sh = {rem_ff, num_ff[63]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign rem_nx = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_MUL1;
      end else begin
         state_ff <= state_in;
      end
      case (state_ff)
         CFG_MUL1: p1_ff <= 32'(grav_ff) * 32'(ampl_ff);
         CFG_MUL2: p2_ff <= 48'(p1_ff) * 48'(wave_ff);
         CFG_MUL3: begin
            num_ff <= 64'(p2_ff) * 64'(AMP_SCALE);
            rem_ff <= '0;
            cnt_ff <= 6'd63;
            dvs_ff <= (cor_ff == 16'd0) ? 16'd1 : cor_ff;
         end
         CFG_DIV: begin
            num_ff <= {num_ff[62:0], ge};
            rem_ff <= rem_nx[15:0];
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) amp_ff <= {num_ff[62:0], ge};
         end
         default: ;
      endcase
   end

   logic                        rot_valid;
   logic signed [FRAC_BITS+1:0] rc, rs, rc_ff, rs_ff;
   scf_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_rot (
      .clock(clock), .reset(reset), .en(1'b1), .in_valid(rot_start),
      .in_turn({rotation_ff, 16'h0}), .out_valid(rot_valid), .out_cos(rc), .out_sin(rs)
   );
   always_ff @(posedge clock) begin
      if (rot_valid) begin
         rc_ff <= rc;
         rs_ff <= rs;
      end
   end

   assign rot_cos   = rc_ff;
   assign rot_sin   = rs_ff;
   assign cfg.busy  = busy;
   assign cfg.wave  = wave_ff;
   assign cfg.off_x = off_x_ff;
   assign cfg.off_y = off_y_ff;
   assign cfg.amp   = amp_ff;
endmodule
`default_nettype wire

/* test/tb_top.sv */
// Testbench for spectral_current_field_top: directed table, random positions, drift predictor.
`timescale 1ns / 1ps
module tb_top;
   import scf_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                 known;
      logic signed [31:0] e;
      logic signed [31:0] n;
   } row_type;

   typedef struct {
      logic signed [31:0] e;
      logic signed [31:0] n;
   } drift_type;

   localparam int CLAMP_BITS = 36;
   localparam int DRAIN_CYCLES = 80;
   localparam int STALL_LIMIT = 5000;
   localparam logic [31:0] ATAN_TURNS [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0;
   logic rsp_stall = 0;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0;
   wire req_stall, rsp_valid, pready;
   wire signed [31:0] rsp_drift_east, rsp_drift_north;
   wire [31:0] prdata;

   logic [15:0] cfg [7];
   drift_type pending [$];
   int errors = 0;
   int idle_cycles = 0;
   bit steady = 0;

   always #6 clock = ~clock;

   spectral_current_field_top uut (.*);

   // -- predictor ------------------------------------------------------------
   function automatic void cordic_cos_sin(input logic [31:0] turn,
                                          output longint co, output longint si);
      logic [31:0] t;
      bit flip;
      longint x, y, z, dx, dy;
      t = turn + 32'h40000000;
      flip = t[31];
      if (flip) turn = turn + 32'h80000000;
      z = longint'($signed(turn));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      co = (x + 8192) >>> 14;
      si = (y + 8192) >>> 14;
   endfunction

   function automatic logic [31:0] wave_phase(input longint pos, input logic [15:0] off);
      logic [63:0] p;
      p = {48'd0, cfg[REG_WAVE]} * 64'(pos) * 64'd777472128;
      return p[55:24] + {off, 16'h0000};
   endfunction

   function automatic longint field_part(input logic [63:0] amp, input longint cq);
      logic [63:0] m, mag;
      m = cq < 0 ? 64'(-cq) : 64'(cq);
      if (m == 0) return 0;
      if (amp > 64'hFFFF_FFFF_FFFF_FFFF / m) mag = 64'd1 << CLAMP_BITS;
      else mag = (amp * m) >> 30;
      if (mag > (64'd1 << CLAMP_BITS)) mag = 64'd1 << CLAMP_BITS;
      return cq < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [31:0] saturate(input longint v);
      v = v >>> 16;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic drift_type predict_drift(input logic signed [31:0] px,
                                               input logic signed [31:0] py);
      longint x, y, c, s, fx, fy, cx, cy, dummy, dx, dy;
      logic [63:0] f, amp;
      drift_type r;
      x = px;
      y = py;
      f = cfg[REG_CORIOLIS] == 0 ? 64'd1 : 64'(cfg[REG_CORIOLIS]);
      amp = 64'(cfg[REG_GRAVITY]) * 64'(cfg[REG_AMPLITUDE]) * 64'(cfg[REG_WAVE]) * 64'd33733;
      amp = amp / f;
      cordic_cos_sin({cfg[REG_ROTATION], 16'h0000}, c, s);
      fx = (c * x + s * y) >>> 16;
      fy = (c * y - s * x) >>> 16;
      cordic_cos_sin(wave_phase(fx, cfg[REG_OFFSET_X]), cx, dummy);
      cordic_cos_sin(wave_phase(fy, cfg[REG_OFFSET_Y]), cy, dummy);
      dx = -field_part(amp, cy);
      dy = field_part(amp, cx);
      r.e = saturate(c * dx - s * dy);
      r.n = saturate(s * dx + c * dy);
      return r;
   endfunction

   // -- checking -------------------------------------------------------------
   task automatic report(input string what);
      errors++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      drift_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            report("drift result with no request waiting");
         end else begin
            want = pending.pop_front();
            if (rsp_drift_east !== want.e)
               report($sformatf("east %0d, want %0d", rsp_drift_east, want.e));
            if (rsp_drift_north !== want.n)
               report($sformatf("north %0d, want %0d", rsp_drift_north, want.n));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("spectral_current_field_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 9);

   // -- stimulus -------------------------------------------------------------
   task automatic csr_write(input scf_reg_type idx, input logic [15:0] val);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {idx, 2'b00};
      pwdata <= {16'h0, val};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      cfg[idx] = val;
   endtask

   task automatic load_setting(input logic [15:0] v [7]);
      for (int i = 0; i < 7; i++) csr_write(scf_reg_type'(i), v[i]);
   endtask

   task automatic drain();
      wait (pending.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send(input row_type r);
      drift_type d;
      // an idle gap before about 4 requests in a hundred
      if (!steady && $urandom_range(99) < 4) begin
         req_valid <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      if (r.known) begin
         d.e = r.e; d.n = r.n;
      end else begin
         d = predict_drift(r.x, r.y);
      end
      pending.push_back(d);
      req_valid <= 1;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_pos();
      int k;
      k = $urandom_range(99);
      if (k < 40) return $signed($urandom_range(2097152)) - 32'sd1048576;
      if (k < 75) return $urandom();
      if (k < 85) return $signed($urandom_range(51200000)) - 32'sd25600000;
      case ($urandom_range(3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic logic [15:0] rand_reg(input int mode);
      case (mode)
         0: return 16'($urandom_range(65535));
         1: return 16'($urandom_range(1024));
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   row_type reset_rows [6] = '{
      '{32'sd0, 32'sd0, 1, 32'sd0, 32'sd0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 32'sd0, 32'sd0},
      '{32'sh80000000, 32'sh80000000, 1, 32'sd0, 32'sd0},
      '{32'sh7FFFFFFF, 32'sh80000000, 1, 32'sd0, 32'sd0},
      '{32'sd1, -32'sd1, 1, 32'sd0, 32'sd0},
      '{32'sd256000, -32'sd256000, 1, 32'sd0, 32'sd0}};

   row_type edge_rows [8] = '{
      '{32'sd0, 32'sd0, 0, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0},
      '{32'sh80000000, 32'sh80000000, 0, 0, 0},
      '{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0},
      '{32'sd362039, 32'sd0, 0, 0, 0},
      '{32'sd0, -32'sd362039, 0, 0, 0},
      '{32'sd1, 32'sd1, 0, 0, 0},
      '{-32'sd1, 32'sd256, 0, 0, 0}};

   initial begin
      logic [15:0] v [7];
      row_type r;
      cfg = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2114, 16'd2511};
      repeat (9) @(posedge clock);
      reset <= 0;

      // reset state: zero wave number and amplitude give zero drift
      foreach (reset_rows[i]) send(reset_rows[i]);
      req_valid <= 0;
      drain();

      // huge drift with zero coriolis (treated as one): field clamp and output saturation
      v = '{16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF};
      load_setting(v);
      foreach (edge_rows[i]) send(edge_rows[i]);
      req_valid <= 0;
      drain();
      // rotated, wrapping phase offsets, moderate field
      v = '{16'd16384, 16'hFFFF, 16'h8000, 16'd256, 16'd2560, 16'd2114, 16'd2511};
      load_setting(v);
      foreach (edge_rows[i]) send(edge_rows[i]);
      req_valid <= 0;
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < 7; i++) v[i] = rand_reg(ph % 3);
         if (ph == 3) v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
         if (ph == 4) v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000};
         if (ph == 6) begin
            v[REG_WAVE] = 16'($urandom_range(4096));
            v[REG_CORIOLIS] = 16'($urandom_range(4096, 1024));
         end
         load_setting(v);
         steady = (ph == 5);
         for (int n = 0; n < 235; n++) begin
            r.x = rand_pos();
            r.y = rand_pos();
            r.known = 0;
            send(r);
            if (ph == 2 && n == 100) begin
               // hold off until the pipeline is empty
               req_valid <= 0;
               wait (pending.size() == 0);
               @(posedge clock);
            end
         end
         req_valid <= 0;
         steady = 0;
         drain();
      end

      if (errors == 0) $display("spectral_current_field_top: match");
      else $display("spectral_current_field_top: mismatch");
      $finish;
   end
endmodule
